// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the ordered table modules.
// Each use expects clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define OTIS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define OTIS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/otis_pkg.sv -----
// Shared types and codes for the ordered table block.
// No dependencies; used by every module of the block but otis_ram.
package otis_pkg;

	localparam int DEPTH_DEF = 16;

	localparam int REQ_W     = 3;
	localparam int POS_W     = 5;
	localparam int KEY_W     = 16;
	localparam int PAY_W     = 32;
	localparam int STAT_W    = 2;
	localparam int FPOS_W    = 4;
	localparam int CNT_OUT_W = 5;

	localparam logic [REQ_W-1:0] REQ_INSERT     = 3'd0;
	localparam logic [REQ_W-1:0] REQ_READ       = 3'd1;
	localparam logic [REQ_W-1:0] REQ_WRITE      = 3'd2;
	localparam logic [REQ_W-1:0] REQ_FIND       = 3'd3;
	localparam logic [REQ_W-1:0] REQ_REMOVE_AT  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_REMOVE_KEY = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_MISS  = 2'd3;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [POS_W-1:0] position;
		logic [KEY_W-1:0] entry_key;
		logic [PAY_W-1:0] entry_payload;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]    status;
		logic [FPOS_W-1:0]    found_position;
		logic [KEY_W-1:0]     out_key;
		logic [PAY_W-1:0]     out_payload;
		logic [CNT_OUT_W-1:0] entry_count;
		logic                 is_empty;
	} res_t;

	// one slot of the table as stored in RAM
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} slot_t;

	// where the RAM read address points relative to the index register
	typedef enum logic [1:0] {
		RD_IDX,
		RD_IDX_DN,
		RD_IDX_UP
	} rd_sel_t;

	typedef struct packed {
		logic              load_req;
		logic              idx_ld_cnt;
		logic              idx_ld_pos;
		logic              idx_ld_zero;
		logic              idx_inc;
		logic              idx_dec;
		logic              rd_en;
		rd_sel_t           rd_sel;
		logic              wr_en;
		logic              wr_new;
		logic              cnt_inc;
		logic              cnt_dec;
		logic              cap_out;
		logic              cap_fpos;
		logic              set_status;
		logic [STAT_W-1:0] status_code;
		logic              out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic             ins_bad;
		logic             pos_bad;
		logic             full;
		logic             idx_gt_pos;
		logic             idx_end;
		logic             idx_last;
		logic             key_hit;
		logic             out_free;
	} dp_sts_t;

endpackage

// ----- rtl/otis_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module otis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/otis_dp.sv -----
// Datapath of the ordered table: request, count and index registers, slot RAM,
// result register. Depends on otis_pkg, otis_ram and assert_macros.svh.
`include "assert_macros.svh"

module otis_dp #(
	parameter int DEPTH = otis_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  otis_pkg::req_t     req_data,
	input  otis_pkg::ctl_cmd_t cmd,
	output otis_pkg::dp_sts_t  sts,
	output otis_pkg::res_t     res_data,
	output logic               res_valid,
	input  logic               res_stall
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CMP_W = (CW > otis_pkg::POS_W) ? CW : otis_pkg::POS_W;

	otis_pkg::req_t                 req_q;
	logic [CW-1:0]                  cnt_q;
	logic [CW-1:0]                  idx_q;
	logic [otis_pkg::STAT_W-1:0]    status_q;
	logic [otis_pkg::FPOS_W-1:0]    fpos_q;
	logic [otis_pkg::KEY_W-1:0]     okey_q;
	logic [otis_pkg::PAY_W-1:0]     opay_q;
	otis_pkg::res_t                 res_q;
	logic                           res_valid_q;

	logic [CW-1:0]                  rd_idx;
	logic [AW-1:0]                  rd_addr;
	otis_pkg::slot_t                rd_slot;
	otis_pkg::slot_t                wr_slot;
	logic [CMP_W-1:0]               pos_x;
	logic [CMP_W-1:0]               cnt_x;
	logic [CMP_W-1:0]               idx_x;
	logic [CW:0]                    idx_nxt;

	// slot storage
	always_comb begin
		unique case (cmd.rd_sel)
			otis_pkg::RD_IDX:    rd_idx = idx_q;
			otis_pkg::RD_IDX_DN: rd_idx = idx_q - CW'(1);
			otis_pkg::RD_IDX_UP: rd_idx = idx_q + CW'(1);
			default:             rd_idx = idx_q;
		endcase
	end

	assign rd_addr = rd_idx[AW-1:0];
	assign wr_slot = cmd.wr_new ? {req_q.entry_key, req_q.entry_payload} : rd_slot;

	otis_ram #(
		.WIDTH($bits(otis_pkg::slot_t)),
		.DEPTH(DEPTH)
	) u_slots (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (idx_q[AW-1:0]),
		.wr_data (wr_slot),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_slot)
	);

	// request and result fields
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req_data;
		end
		if (cmd.load_req) begin
			status_q <= otis_pkg::STAT_OK;
			fpos_q   <= '0;
			okey_q   <= '0;
			opay_q   <= '0;
		end else begin
			if (cmd.set_status) begin
				status_q <= cmd.status_code;
			end
			if (cmd.cap_fpos) begin
				fpos_q <= otis_pkg::FPOS_W'(idx_q);
			end
			if (cmd.cap_out) begin
				okey_q <= rd_slot.key;
				opay_q <= rd_slot.payload;
			end
		end
		if (cmd.out_load) begin
			res_q.status         <= status_q;
			res_q.found_position <= fpos_q;
			res_q.out_key        <= okey_q;
			res_q.out_payload    <= opay_q;
			res_q.entry_count    <= otis_pkg::CNT_OUT_W'(cnt_q);
			res_q.is_empty       <= (cnt_q == '0);
		end
	end

	// count, index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			priority if (cmd.idx_ld_cnt) begin
				idx_q <= cnt_q;
			end else if (cmd.idx_ld_pos) begin
				idx_q <= CW'(req_q.position);
			end else if (cmd.idx_ld_zero) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end else if (cmd.idx_dec) begin
				idx_q <= idx_q - CW'(1);
			end
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// status toward the controller
	assign pos_x   = CMP_W'(req_q.position);
	assign cnt_x   = CMP_W'(cnt_q);
	assign idx_x   = CMP_W'(idx_q);
	assign idx_nxt = (CW + 1)'(idx_q) + (CW + 1)'(1);

	always_comb begin
		sts.req_type   = req_q.req_type;
		sts.ins_bad    = pos_x > cnt_x;
		sts.pos_bad    = pos_x >= cnt_x;
		sts.full       = cnt_q == CW'(DEPTH);
		sts.idx_gt_pos = idx_x > pos_x;
		sts.idx_end    = idx_q >= cnt_q;
		sts.idx_last   = idx_nxt >= (CW + 1)'(cnt_q);
		sts.key_hit    = rd_slot.key == req_q.entry_key;
		sts.out_free   = !res_valid_q || !res_stall;
	end

	assign res_data  = res_q;
	assign res_valid = res_valid_q;

	`OTIS_ASSERT_NOW(a_inc_not_full, cmd.cnt_inc, cnt_q < CW'(DEPTH), "insert into a full table")
	`OTIS_ASSERT_NOW(a_dec_not_empty, cmd.cnt_dec, cnt_q != '0, "remove from an empty table")
	`OTIS_ASSERT_NOW(a_wr_in_range, cmd.wr_en, idx_q <= cnt_q && idx_q < CW'(DEPTH),
		"slot write beyond the held entries")
	`OTIS_ASSERT_NEXT(a_inc_nonempty, cmd.cnt_inc, cnt_q != '0, "count not raised by insert")

endmodule

// ----- rtl/otis_ctrl.sv -----
// Controller of the ordered table: sequences shifts, scans and slot accesses.
// Depends on otis_pkg and assert_macros.svh; drives otis_dp by command struct.
`include "assert_macros.svh"

module otis_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  otis_pkg::dp_sts_t  sts,
	output otis_pkg::ctl_cmd_t cmd
);

	typedef enum logic [3:0] {
		IDLE,
		DECODE,
		INS_CHK,
		INS_WR,
		PUT,
		POS_RD,
		POS_USE,
		SCAN_CHK,
		SCAN_USE,
		REM_RD,
		REM_USE,
		SHIFT_CHK,
		SHIFT_WR,
		FINISH
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign req_stall = (state_q != IDLE);

	always_comb begin
		cmd             = '0;
		cmd.rd_sel      = otis_pkg::RD_IDX;
		cmd.status_code = otis_pkg::STAT_OK;
		state_nxt       = state_q;
		unique case (state_q)
			IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_nxt    = DECODE;
				end
			end
			DECODE: begin
				unique case (sts.req_type)
					otis_pkg::REQ_INSERT: begin
						if (sts.ins_bad) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = otis_pkg::STAT_RANGE;
							state_nxt       = FINISH;
						end else if (sts.full) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = otis_pkg::STAT_FULL;
							state_nxt       = FINISH;
						end else begin
							cmd.idx_ld_cnt = 1'b1;
							state_nxt      = INS_CHK;
						end
					end
					otis_pkg::REQ_READ, otis_pkg::REQ_WRITE: begin
						if (sts.pos_bad) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = otis_pkg::STAT_RANGE;
							state_nxt       = FINISH;
						end else begin
							cmd.idx_ld_pos = 1'b1;
							state_nxt      = POS_RD;
						end
					end
					otis_pkg::REQ_FIND, otis_pkg::REQ_REMOVE_KEY: begin
						cmd.idx_ld_zero = 1'b1;
						state_nxt       = SCAN_CHK;
					end
					otis_pkg::REQ_REMOVE_AT: begin
						if (sts.pos_bad) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = otis_pkg::STAT_RANGE;
							state_nxt       = FINISH;
						end else begin
							cmd.idx_ld_pos = 1'b1;
							state_nxt      = REM_RD;
						end
					end
					default: begin
						// unused codes report ok with zero fields
						state_nxt = FINISH;
					end
				endcase
			end
			INS_CHK: begin
				// move the entry below the index up one slot
				if (sts.idx_gt_pos) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = otis_pkg::RD_IDX_DN;
					state_nxt  = INS_WR;
				end else begin
					state_nxt = PUT;
				end
			end
			INS_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.idx_dec = 1'b1;
				state_nxt   = INS_CHK;
			end
			PUT: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_new  = 1'b1;
				cmd.cnt_inc = 1'b1;
				state_nxt   = FINISH;
			end
			POS_RD: begin
				cmd.rd_en = 1'b1;
				state_nxt = POS_USE;
			end
			POS_USE: begin
				cmd.cap_out = 1'b1;
				if (sts.req_type == otis_pkg::REQ_WRITE) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_new = 1'b1;
				end
				state_nxt = FINISH;
			end
			SCAN_CHK: begin
				if (sts.idx_end) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = otis_pkg::STAT_MISS;
					state_nxt       = FINISH;
				end else begin
					cmd.rd_en = 1'b1;
					state_nxt = SCAN_USE;
				end
			end
			SCAN_USE: begin
				if (sts.key_hit) begin
					cmd.cap_fpos = 1'b1;
					if (sts.req_type == otis_pkg::REQ_REMOVE_KEY) begin
						state_nxt = REM_RD;
					end else begin
						state_nxt = FINISH;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt   = SCAN_CHK;
				end
			end
			REM_RD: begin
				cmd.rd_en = 1'b1;
				state_nxt = REM_USE;
			end
			REM_USE: begin
				cmd.cap_out = 1'b1;
				state_nxt   = SHIFT_CHK;
			end
			SHIFT_CHK: begin
				// pull the entry above the index down one slot
				if (sts.idx_last) begin
					cmd.cnt_dec = 1'b1;
					state_nxt   = FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = otis_pkg::RD_IDX_UP;
					state_nxt  = SHIFT_WR;
				end
			end
			SHIFT_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.idx_inc = 1'b1;
				state_nxt   = SHIFT_CHK;
			end
			FINISH: begin
				// hold until the output register is free
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = IDLE;
				end
			end
			default: begin
				state_nxt = IDLE;
			end
		endcase
	end

	`OTIS_ASSERT_NOW(a_load_when_free, cmd.out_load, sts.out_free,
		"result loaded over an item still held")
	`OTIS_ASSERT_NOW(a_no_write_idle, state_q == IDLE || state_q == FINISH, !cmd.wr_en,
		"slot write outside an item")
	`OTIS_ASSERT_NEXT(a_accept_decodes, req_valid && !req_stall, state_q == DECODE,
		"accepted item not decoded")

endmodule

// ----- rtl/ordered_table_insert_remove_search.sv -----
// Ordered table, top level. Rejects and unused codes go straight to the result; a read or
// overwrite reads the slot once; inserts, removes and key scans move or compare one entry
// at a time (one read, then a write or compare on the single read port of the slot RAM).
// The block takes one item at a time: the next item is taken in the cycle after the result
// is loaded, and a stalled result holds the input. Reset clears the entry count, the index
// and the handshakes only.
module ordered_table_insert_remove_search #(
	parameter int DEPTH = otis_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  otis_pkg::req_t req_data,
	output logic           res_valid,
	input  logic           res_stall,
	output otis_pkg::res_t res_data
);

	otis_pkg::ctl_cmd_t cmd;
	otis_pkg::dp_sts_t  sts;

	otis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	otis_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.sts       (sts),
		.res_data  (res_data),
		.res_valid (res_valid),
		.res_stall (res_stall)
	);

endmodule

// ----- tb/tb_ordered_table_insert_remove_search.sv -----
// Testbench for ordered_table_insert_remove_search: a directed run, then random items.
// Results are checked against a behavioral table tracker held in a scoreboard class.
// Depends on otis_pkg and the RTL of the block only.
module tb_ordered_table_insert_remove_search;

	localparam int TABLE_DEPTH = otis_pkg::DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1250;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER = 300;
	localparam int DRAIN_CYCLES = 4 * TABLE_DEPTH + 20;
	localparam longint unsigned CYCLE_LIMIT = 1000000;
	localparam int REPORT_LINES = 40;

	// request codes the block leaves unused
	localparam logic [otis_pkg::REQ_W-1:0] REQ_SPARE_A = 3'd6;
	localparam logic [otis_pkg::REQ_W-1:0] REQ_SPARE_B = 3'd7;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_e;

	class table_tracker;
		logic [otis_pkg::KEY_W-1:0] keys_held[TABLE_DEPTH];
		logic [otis_pkg::PAY_W-1:0] pays_held[TABLE_DEPTH];
		int unsigned entries;
		otis_pkg::res_t expected_results[$];
		int mismatches;
		int results_checked;

		function new();
			entries = 0;
			mismatches = 0;
			results_checked = 0;
		endfunction

		// take one entry out and close the hole
		function void pull_entry(int unsigned at, inout otis_pkg::res_t r);
			int unsigned i;
			r.out_key = keys_held[at];
			r.out_payload = pays_held[at];
			for (i = at + 1; i < entries; i++) begin
				keys_held[i - 1] = keys_held[i];
				pays_held[i - 1] = pays_held[i];
			end
			entries--;
		endfunction

		function void apply_request(otis_pkg::req_t rq);
			otis_pkg::res_t r;
			int hit;
			int unsigned i;
			r = '0;
			hit = -1;
			case (rq.req_type)
				otis_pkg::REQ_INSERT: begin
					if (rq.position > entries)
						r.status = otis_pkg::STAT_RANGE;
					else if (entries >= TABLE_DEPTH)
						r.status = otis_pkg::STAT_FULL;
					else begin
						for (i = entries; i > rq.position; i--) begin
							keys_held[i] = keys_held[i - 1];
							pays_held[i] = pays_held[i - 1];
						end
						keys_held[rq.position] = rq.entry_key;
						pays_held[rq.position] = rq.entry_payload;
						entries++;
					end
				end
				otis_pkg::REQ_READ, otis_pkg::REQ_WRITE: begin
					if (rq.position >= entries)
						r.status = otis_pkg::STAT_RANGE;
					else begin
						r.out_key = keys_held[rq.position];
						r.out_payload = pays_held[rq.position];
						if (rq.req_type == otis_pkg::REQ_WRITE) begin
							keys_held[rq.position] = rq.entry_key;
							pays_held[rq.position] = rq.entry_payload;
						end
					end
				end
				otis_pkg::REQ_FIND, otis_pkg::REQ_REMOVE_KEY: begin
					for (i = 0; i < entries; i++)
						if (hit < 0 && keys_held[i] == rq.entry_key)
							hit = i;
					if (hit < 0)
						r.status = otis_pkg::STAT_MISS;
					else begin
						r.found_position = otis_pkg::FPOS_W'(hit);
						if (rq.req_type == otis_pkg::REQ_REMOVE_KEY)
							pull_entry(hit, r);
					end
				end
				otis_pkg::REQ_REMOVE_AT: begin
					if (rq.position >= entries)
						r.status = otis_pkg::STAT_RANGE;
					else
						pull_entry(rq.position, r);
				end
				default: ;
			endcase
			r.entry_count = otis_pkg::CNT_OUT_W'(entries);
			r.is_empty = (entries == 0);
			expected_results.push_back(r);
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= REPORT_LINES)
				$display("[%0t] result %0d: %s", $time, results_checked, msg);
		endtask

		task compare_field(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
		endtask

		task check_result(otis_pkg::res_t got);
			otis_pkg::res_t want;
			results_checked++;
			if (expected_results.size() == 0) begin
				report("result with no request outstanding");
				return;
			end
			want = expected_results.pop_front();
			compare_field("status", 64'(got.status), 64'(want.status));
			compare_field("found_position", 64'(got.found_position),
				64'(want.found_position));
			compare_field("out_key", 64'(got.out_key), 64'(want.out_key));
			compare_field("out_payload", 64'(got.out_payload), 64'(want.out_payload));
			compare_field("entry_count", 64'(got.entry_count), 64'(want.entry_count));
			compare_field("is_empty", 64'(got.is_empty), 64'(want.is_empty));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	otis_pkg::req_t req_data;
	logic res_valid;
	logic res_stall;
	otis_pkg::res_t res_data;

	table_tracker tracker = new();
	longint unsigned cycles = 0;

	ordered_table_insert_remove_search #(
		.DEPTH(TABLE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("ordered_table_insert_remove_search test failed");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task send(input otis_pkg::req_t rq);
		req_data <= rq;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		tracker.apply_request(rq);
		@(negedge clk);
	endtask

	// receiver: check at the rising edge, pick the next stall at the falling edge
	initial begin
		int hold_left;
		bit held;
		stall_mode_e mode;
		int mode_left;
		res_stall = 1'b0;
		hold_left = 0;
		held = 0;
		mode = STALL_NONE;
		mode_left = 150;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall)
				tracker.check_result(res_data);
			@(negedge clk);
			// hold off once so the block backs up into its input
			if (!held && tracker.results_checked >= HOLD_AFTER) begin
				held = 1;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode = stall_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				case (mode)
					STALL_NONE:     res_stall <= 1'b0;
					STALL_LIGHT:    res_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY:    res_stall <= ($urandom_range(0, 9) < 7);
					STALL_PERIODIC: res_stall <= (mode_left % 5 == 0);
				endcase
			end
		end
	end

	initial begin
		otis_pkg::req_t rq;
		int sent;
		int burst_left;
		int gap;
		int seg_left;
		bit filling;
		int unsigned pick;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table: every request is rejected or misses
		send(otis_pkg::req_t'{otis_pkg::REQ_READ, 5'd0, 16'h0000, 32'h0000_0000});
		send(otis_pkg::req_t'{otis_pkg::REQ_REMOVE_AT, 5'd0, 16'h0000, 32'h0000_0000});
		send(otis_pkg::req_t'{otis_pkg::REQ_FIND, 5'd0, 16'h0000, 32'h0000_0000});
		send(otis_pkg::req_t'{otis_pkg::REQ_REMOVE_KEY, 5'd0, 16'hffff, 32'h0000_0000});
		send(otis_pkg::req_t'{otis_pkg::REQ_INSERT, 5'd1, 16'h0001, 32'h0000_0001});
		send(otis_pkg::req_t'{otis_pkg::REQ_INSERT, 5'd31, 16'h0002, 32'h0000_0002});
		// build [1234, ffff, ffff, 0000] with inserts at end, front and middle
		send(otis_pkg::req_t'{otis_pkg::REQ_INSERT, 5'd0, 16'hffff, 32'hffff_ffff});
		send(otis_pkg::req_t'{otis_pkg::REQ_INSERT, 5'd1, 16'h0000, 32'h0000_0000});
		send(otis_pkg::req_t'{otis_pkg::REQ_INSERT, 5'd0, 16'h1234, 32'ha5a5_a5a5});
		send(otis_pkg::req_t'{otis_pkg::REQ_INSERT, 5'd1, 16'hffff, 32'h0000_0001});
		send(otis_pkg::req_t'{otis_pkg::REQ_FIND, 5'd0, 16'hffff, 32'h0000_0000});
		send(otis_pkg::req_t'{otis_pkg::REQ_READ, 5'd3, 16'h0000, 32'h0000_0000});
		send(otis_pkg::req_t'{otis_pkg::REQ_READ, 5'd4, 16'h0000, 32'h0000_0000});
		send(otis_pkg::req_t'{otis_pkg::REQ_WRITE, 5'd4, 16'h7777, 32'h7777_7777});
		send(otis_pkg::req_t'{otis_pkg::REQ_WRITE, 5'd2, 16'h5555, 32'h5a5a_5a5a});
		send(otis_pkg::req_t'{otis_pkg::REQ_REMOVE_AT, 5'd4, 16'h0000, 32'h0000_0000});
		send(otis_pkg::req_t'{otis_pkg::REQ_REMOVE_KEY, 5'd0, 16'hffff, 32'h0000_0000});
		send(otis_pkg::req_t'{otis_pkg::REQ_REMOVE_KEY, 5'd0, 16'h0007, 32'h0000_0000});
		send(otis_pkg::req_t'{REQ_SPARE_A, 5'd0, 16'h0000, 32'h0000_0000});
		send(otis_pkg::req_t'{REQ_SPARE_B, 5'd31, 16'hffff, 32'hffff_ffff});
		send(otis_pkg::req_t'{otis_pkg::REQ_REMOVE_AT, 5'd0, 16'h0000, 32'h0000_0000});
		send(otis_pkg::req_t'{otis_pkg::REQ_REMOVE_AT, 5'd1, 16'h0000, 32'h0000_0000});
		send(otis_pkg::req_t'{otis_pkg::REQ_READ, 5'd31, 16'h0000, 32'h0000_0000});
		send(otis_pkg::req_t'{otis_pkg::REQ_REMOVE_KEY, 5'd0, 16'h5555, 32'h0000_0000});
		send(otis_pkg::req_t'{otis_pkg::REQ_FIND, 5'd0, 16'h5555, 32'h0000_0000});

		// random part: alternate fill-heavy and drain-heavy stretches
		sent = 0;
		burst_left = 0;
		filling = 1;
		seg_left = 60;
		while (sent < RANDOM_ITEMS) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					req_valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			burst_left--;
			if (seg_left == 0) begin
				filling = !filling;
				seg_left = $urandom_range(40, 120);
			end
			seg_left--;

			pick = $urandom_range(0, 99);
			if (pick < 5)
				rq.req_type = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
			else if (pick < (filling ? 60 : 25))
				rq.req_type = otis_pkg::REQ_INSERT;
			else if (pick < (filling ? 70 : 35))
				rq.req_type = otis_pkg::REQ_READ;
			else if (pick < (filling ? 80 : 45))
				rq.req_type = otis_pkg::REQ_WRITE;
			else if (pick < (filling ? 88 : 55))
				rq.req_type = otis_pkg::REQ_FIND;
			else if (pick < (filling ? 94 : 78))
				rq.req_type = otis_pkg::REQ_REMOVE_AT;
			else
				rq.req_type = otis_pkg::REQ_REMOVE_KEY;

			// small keys make duplicates and hits common
			rq.entry_key = $urandom_range(0, 1) ? 16'($urandom_range(0, 15)) : 16'($urandom);
			rq.entry_payload = $urandom;
			if ((rq.req_type == otis_pkg::REQ_FIND || rq.req_type == otis_pkg::REQ_REMOVE_KEY)
					&& tracker.entries > 0 && $urandom_range(0, 3) != 0)
				rq.entry_key = tracker.keys_held[$urandom_range(0, tracker.entries - 1)];

			if ($urandom_range(0, 6) == 0)
				rq.position = 5'($urandom_range(0, 31));
			else if (rq.req_type == otis_pkg::REQ_INSERT)
				rq.position = 5'($urandom_range(0, tracker.entries));
			else if (tracker.entries > 0)
				rq.position = 5'($urandom_range(0, tracker.entries - 1));
			else
				rq.position = '0;

			send(rq);
			if (rq.req_type != REQ_SPARE_A && rq.req_type != REQ_SPARE_B)
				sent++;
		end
		req_valid <= 1'b0;

		while (tracker.expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("ordered_table_insert_remove_search test passed");
		else
			$display("ordered_table_insert_remove_search test failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/otis_pkg.sv
rtl/otis_ram.sv
rtl/otis_dp.sv
rtl/otis_ctrl.sv
rtl/ordered_table_insert_remove_search.sv
tb/tb_ordered_table_insert_remove_search.sv
